>>> design/rlyip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relay interlock pulse controller package
// Shared sizes, register indexes and types for the controller datapath.
// ----------------------------------------------------------------------------
package rlyip_pkg;

    localparam int CHANNEL_COUNT  = 4;
    localparam int COUNT_BITS     = 16;
    localparam int PERIOD_BITS    = 16;
    localparam int RELAY_BITS     = 4;
    localparam int KEY_BITS       = 4;
    localparam int LOCK_BITS      = 3;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CMP_BITS       = (COUNT_BITS > PERIOD_BITS) ? COUNT_BITS : PERIOD_BITS;

    localparam int PULSE_LEAD     = 5;
    localparam int HOLD_TICKS     = 5;
    localparam int PERIOD_RESET   = 50;

    typedef logic [CHANNEL_COUNT-1:0] chan_vec_t;
    typedef logic [COUNT_BITS-1:0]    count_t;
    typedef logic [PERIOD_BITS-1:0]   period_t;
    typedef logic [LOCK_BITS-1:0]     lock_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_LOCK_MODE    = 2'd0,
        CFG_JOG_MASK     = 2'd1,
        CFG_PULSE_PERIOD = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic      lock_mode;
        chan_vec_t jog_mask;
        period_t   pulse_period;
    } cfg_t;

    typedef struct packed {
        chan_vec_t key_levels;
        lock_t     held_channel;
    } tick_result_t;

endpackage

>>> design/rlyip_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// Write-only register file for mode, jog mask and pulse period.
// ----------------------------------------------------------------------------
module rlyip_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rlyip_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rlyip_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output rlyip_pkg::cfg_t                      cfg
);
    import rlyip_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_LOCK_MODE:    cfg_next.lock_mode    = cfg_data[0];
                CFG_JOG_MASK:     cfg_next.jog_mask     = cfg_data[CHANNEL_COUNT-1:0];
                CFG_PULSE_PERIOD: cfg_next.pulse_period = cfg_data[PERIOD_BITS-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lock_mode    <= 1'b0;
            cfg_reg.jog_mask     <= '0;
            cfg_reg.pulse_period <= period_t'(PERIOD_RESET);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/rlyip_tick_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick engine
// Channel counters, arm flags, lock state and key drive, updated once per
// request in a single combinational pass.
// ----------------------------------------------------------------------------
module rlyip_tick_engine (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step_en,
    input  rlyip_pkg::chan_vec_t    relays,
    input  rlyip_pkg::cfg_t         cfg,
    output rlyip_pkg::tick_result_t result
);
    import rlyip_pkg::*;

    count_t    counts_reg [CHANNEL_COUNT];
    count_t    counts_next[CHANNEL_COUNT];
    count_t    counts_inc [CHANNEL_COUNT];
    chan_vec_t armed_reg;
    chan_vec_t armed_next;
    chan_vec_t key_reg;
    chan_vec_t key_next;
    chan_vec_t prev_relay_reg;
    chan_vec_t prev_relay_next;
    chan_vec_t rising;
    lock_t     locked_reg;
    lock_t     locked_next;
    lock_t     prev_locked_reg;
    lock_t     prev_locked_next;
    period_t   press_at;
    logic      lead_ok;

    assign rising   = relays & ~prev_relay_reg;
    assign lead_ok  = cfg.pulse_period >= period_t'(PULSE_LEAD);
    assign press_at = cfg.pulse_period - period_t'(PULSE_LEAD);

    always_comb
    begin
        for (int i = 0; i < CHANNEL_COUNT; i++)
        begin
            counts_inc[i] = counts_reg[i] + count_t'(1);
        end
    end

    always_comb
    begin
        counts_next      = counts_reg;
        armed_next       = armed_reg;
        key_next         = key_reg;
        locked_next      = locked_reg;
        prev_locked_next = prev_locked_reg;
        prev_relay_next  = prev_relay_reg;

        if (!cfg.lock_mode)
        begin
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                counts_next[i] = counts_inc[i];
                if (cfg.jog_mask[i])
                begin
                    if (relays[i] && !armed_reg[i])
                    begin
                        counts_next[i] = '0;
                        armed_next[i]  = 1'b1;
                    end
                    else if (armed_reg[i] && relays[i] && lead_ok &&
                             CMP_BITS'(counts_inc[i]) == CMP_BITS'(press_at))
                    begin
                        key_next[i] = 1'b0;
                    end
                    else if (armed_reg[i] && relays[i] &&
                             CMP_BITS'(counts_inc[i]) == CMP_BITS'(cfg.pulse_period))
                    begin
                        key_next[i]   = 1'b1;
                        armed_next[i] = 1'b0;
                    end
                    else if (!relays[i] && armed_reg[i])
                    begin
                        armed_next[i] = 1'b0;
                    end
                end
            end
        end
        else
        begin
            // highest rising channel wins
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                if (rising[i])
                begin
                    locked_next = LOCK_BITS'(i + 1);
                end
                counts_next[i] = counts_inc[i];
            end
            prev_relay_next = relays;
            if (prev_locked_reg != locked_next)
            begin
                for (int i = 0; i < CHANNEL_COUNT; i++)
                begin
                    counts_next[i] = '0;
                end
                prev_locked_next = locked_next;
            end
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                if (relays[i] && locked_next != LOCK_BITS'(i + 1))
                begin
                    if (counts_next[i] <= count_t'(HOLD_TICKS))
                    begin
                        key_next[i] = 1'b0;
                    end
                    else
                    begin
                        key_next[i]    = 1'b1;
                        counts_next[i] = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                counts_reg[i] <= '0;
            end
            armed_reg       <= '0;
            key_reg         <= '1;
            locked_reg      <= '0;
            prev_locked_reg <= '0;
            prev_relay_reg  <= '0;
        end
        else if (step_en)
        begin
            counts_reg      <= counts_next;
            armed_reg       <= armed_next;
            key_reg         <= key_next;
            locked_reg      <= locked_next;
            prev_locked_reg <= prev_locked_next;
            prev_relay_reg  <= prev_relay_next;
        end
    end

    assign result.key_levels   = key_next;
    assign result.held_channel = locked_next;

`ifndef SYNTHESIS
    a_jog_keeps_lock: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && !cfg.lock_mode |=> $stable(locked_reg) && $stable(prev_relay_reg))
        else $error("lock state changed in jog mode");

    a_lock_keeps_arm: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && cfg.lock_mode |=> $stable(armed_reg))
        else $error("arm flags changed in lock mode");

    a_lock_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && cfg.lock_mode |=> prev_locked_reg == locked_reg)
        else $error("previous lock not tracked");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |=> $stable(key_reg) && $stable(armed_reg))
        else $error("state moved without a request");
`endif

endmodule

>>> design/relay_interlock_pulse_controller.sv
// Latency: request in the input register, then result in the result register.
// Throughput: one request per cycle unless stalled; the single-pass tick engine
// sets the rate. A stalled result holds the input stage; a new request is still
// taken while the result waits as long as the input stage is free.
// Reset: asynchronous, active low; keys released, counters and lock cleared.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relay interlock pulse controller
// Input register, tick engine and result register with valid/stall channels.
// ----------------------------------------------------------------------------
module relay_interlock_pulse_controller (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rlyip_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rlyip_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [rlyip_pkg::RELAY_BITS-1:0]     relay_levels,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [rlyip_pkg::KEY_BITS-1:0]       key_levels,
    output logic [rlyip_pkg::LOCK_BITS-1:0]      held_channel
);
    import rlyip_pkg::*;

    cfg_t         cfg;
    tick_result_t result;
    chan_vec_t    relay_reg;
    logic         s1_valid_reg;
    logic         s1_valid_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic         step_en;
    logic         in_take;
    tick_result_t out_reg;

    assign step_en  = s1_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = s1_valid_reg && !step_en;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (step_en)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step_en)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            relay_reg <= chan_vec_t'(relay_levels);
        end
        if (step_en)
        begin
            out_reg <= result;
        end
    end

    rlyip_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rlyip_tick_engine u_tick_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .relays  (relay_reg),
        .cfg     (cfg),
        .result  (result)
    );

    assign out_valid    = out_valid_reg;
    assign key_levels   = KEY_BITS'(out_reg.key_levels);
    assign held_channel = out_reg.held_channel;

endmodule

>>> tb/rlyip_tick_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relay interlock pulse controller checker
// Watches the config port and both request channels, runs its own tick
// predictor on every accepted request and compares each accepted result with
// the oldest predicted one, field by field.
// ----------------------------------------------------------------------------
module rlyip_tick_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rlyip_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rlyip_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic [rlyip_pkg::RELAY_BITS-1:0]     relay_levels,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic [rlyip_pkg::KEY_BITS-1:0]       key_levels,
    input  logic [rlyip_pkg::LOCK_BITS-1:0]      held_channel,
    output int                                   mismatch_count,
    output int                                   pending_count
);
    import rlyip_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic         lock_mode_q;
    chan_vec_t    jog_mask_q;
    period_t      period_q;
    count_t       tick_count [CHANNEL_COUNT];
    chan_vec_t    armed;
    chan_vec_t    prev_relays;
    chan_vec_t    key_drive;
    lock_t        locked;
    lock_t        prev_locked;
    tick_result_t expected_ticks [$];

    function automatic tick_result_t advance_tick(input chan_vec_t relays);
        logic         on;
        logic         was_armed;
        chan_vec_t    rising;
        tick_result_t res;
        if (!lock_mode_q) begin
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                on = relays[i];
                was_armed = armed[i];
                tick_count[i] = tick_count[i] + 1'b1;
                if (jog_mask_q[i]) begin
                    if (on && !was_armed) begin
                        tick_count[i] = '0;
                        armed[i] = 1'b1;
                    end else if (was_armed && on && period_q >= PULSE_LEAD
                                 && tick_count[i] == period_q - PULSE_LEAD) begin
                        key_drive[i] = 1'b0;
                    end else if (was_armed && on && tick_count[i] == period_q) begin
                        key_drive[i] = 1'b1;
                        armed[i] = 1'b0;
                    end else if (!on && was_armed) begin
                        armed[i] = 1'b0;
                    end
                end
            end
        end else begin
            rising = relays & ~prev_relays;
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                if (rising[i])
                    locked = lock_t'(i + 1);
                tick_count[i] = tick_count[i] + 1'b1;
            end
            prev_relays = relays;
            if (prev_locked != locked) begin
                for (int i = 0; i < CHANNEL_COUNT; i++)
                    tick_count[i] = '0;
                prev_locked = locked;
            end
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                if (relays[i] && locked != lock_t'(i + 1)) begin
                    if (tick_count[i] <= HOLD_TICKS) begin
                        key_drive[i] = 1'b0;
                    end else begin
                        key_drive[i] = 1'b1;
                        tick_count[i] = '0;
                    end
                end
            end
        end
        res.key_levels = key_drive;
        res.held_channel = locked;
        return res;
    endfunction

    task automatic note_mismatch(input string what, input int want_v, input int got_v);
        if (mismatch_count < REPORT_LIMIT)
            $display("%0t mismatch on %s: expected %0d, got %0d", $time, what, want_v, got_v);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        tick_result_t want;
        if (!rst_n) begin
            lock_mode_q = 1'b0;
            jog_mask_q = '0;
            period_q = period_t'(PERIOD_RESET);
            for (int i = 0; i < CHANNEL_COUNT; i++)
                tick_count[i] = '0;
            armed = '0;
            prev_relays = '0;
            key_drive = '1;
            locked = '0;
            prev_locked = '0;
            expected_ticks.delete();
            pending_count = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_LOCK_MODE:    lock_mode_q = cfg_data[0];
                    CFG_JOG_MASK:     jog_mask_q = cfg_data[CHANNEL_COUNT-1:0];
                    CFG_PULSE_PERIOD: period_q = cfg_data[PERIOD_BITS-1:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall) begin
                if (expected_ticks.size() == 0) begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("%0t result with no request pending: keys %0d held %0d",
                                 $time, key_levels, held_channel);
                    mismatch_count++;
                end else begin
                    want = expected_ticks.pop_front();
                    if (key_levels !== want.key_levels)
                        note_mismatch("key_levels", want.key_levels, key_levels);
                    if (held_channel !== want.held_channel)
                        note_mismatch("held_channel", want.held_channel, held_channel);
                end
            end
            if (in_valid && !in_stall)
                expected_ticks.push_back(advance_tick(relay_levels));
            pending_count = expected_ticks.size();
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relay interlock pulse controller testbench
// Drives directed jog and interlock sequences, a short hold at the longest
// period and phases of persistent random relay patterns under varied configs,
// sender gaps and receiver stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import rlyip_pkg::*;

    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_ITEMS     = 160;
    localparam int LONG_HOLD_ITEMS = 40;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int SETTLE_CYCLES   = 8;
    localparam int CYCLE_LIMIT     = 400000;

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [RELAY_BITS-1:0]     relay_levels = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [KEY_BITS-1:0]       key_levels;
    logic [LOCK_BITS-1:0]      held_channel;

    int        mismatches;
    int        pending;
    int        send_idle_pct = 0;
    int        stall_pct = 0;
    int        hold_requests = 0;
    int        requests_sent = 0;
    int        reg_writes = 0;
    int        cycles = 0;
    chan_vec_t relay_state;

    relay_interlock_pulse_controller dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .relay_levels (relay_levels),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .key_levels   (key_levels),
        .held_channel (held_channel)
    );

    rlyip_tick_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .relay_levels   (relay_levels),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .key_levels     (key_levels),
        .held_channel   (held_channel),
        .mismatch_count (mismatches),
        .pending_count  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL relay_interlock_pulse_controller");
            $finish;
        end
    end

    initial
    begin : receiver
        int hold_done;
        hold_done = 0;
        forever
        begin
            @(negedge clk);
            if (hold_done != hold_requests)
            begin
                hold_done = hold_requests;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
        end
    end

    // entered and left at a falling edge; valid stays up for a following request
    task automatic send_tick(input chan_vec_t relays);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        relay_levels <= relays;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        reg_writes++;
    endtask

    // upper data bits carry noise; only the register width counts
    task automatic set_config(input logic lock, input chan_vec_t mask, input period_t period);
        logic [CFG_DATA_BITS-1:0] noise;
        noise = CFG_DATA_BITS'($urandom);
        write_reg(CFG_LOCK_MODE, {noise[CFG_DATA_BITS-1:1], lock});
        noise = CFG_DATA_BITS'($urandom);
        write_reg(CFG_JOG_MASK, {noise[CFG_DATA_BITS-1:CHANNEL_COUNT], mask});
        write_reg(CFG_PULSE_PERIOD, period);
    endtask

    function automatic chan_vec_t next_relays(input chan_vec_t cur, input int flip_pct);
        chan_vec_t nxt;
        nxt = cur;
        if ($urandom_range(99) < 8)
            return chan_vec_t'($urandom);
        for (int i = 0; i < CHANNEL_COUNT; i++)
            if ($urandom_range(99) < flip_pct)
                nxt[i] = ~nxt[i];
        return nxt;
    endfunction

    initial
    begin : stimulus
        int        flip_pct;
        logic      lock_sel;
        chan_vec_t mask_sel;
        period_t   period_sel;
        relay_state = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // reset config: nothing masked, keys stay released
        send_tick(4'h0);
        send_tick(4'hF);

        // jog on all channels, shortest legal period: pulse, re-arm, drop mid-press
        drain_results();
        set_config(1'b0, 4'hF, 16'd6);
        repeat (9) send_tick(4'hF);
        send_tick(4'h0);
        send_tick(4'hF);

        // period below the lead: release only, never a press
        drain_results();
        write_reg(CFG_PULSE_PERIOD, 16'd4);
        repeat (5) send_tick(4'hF);

        // interlock: single lock, lock move, two rising at once, hold then release
        drain_results();
        set_config(1'b1, 4'h0, 16'd50);
        send_tick(4'h1);
        send_tick(4'h3);
        repeat (8) send_tick(4'hC);
        send_tick(4'h8);

        // longest period: armed channel held with no press yet
        drain_results();
        set_config(1'b0, 4'h1, 16'hFFFF);
        repeat (LONG_HOLD_ITEMS) send_tick(4'h1);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain_results();
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 62; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 62; end
                default: begin send_idle_pct = 18; stall_pct = 18; end
            endcase
            lock_sel = 1'($urandom_range(1));
            mask_sel = chan_vec_t'($urandom);
            period_sel = ($urandom_range(9) == 0) ? 16'hFFFF : period_t'($urandom_range(6, 40));
            if (p == 0)
            begin
                lock_sel = 1'b0;
                mask_sel = '1;
                period_sel = 16'd6;
            end
            if (p == 1)
                lock_sel = 1'b1;
            if (p == 4)
            begin
                lock_sel = 1'b0;
                mask_sel = '0;
            end
            set_config(lock_sel, mask_sel, period_sel);
            flip_pct = lock_sel ? $urandom_range(5, 30) : $urandom_range(2, 12);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (p == 0 && k == 30)
                    hold_requests++;
                if (p == 5 && k == 80)
                    drain_results();
                relay_state = next_relays(relay_state, flip_pct);
                send_tick(relay_state);
            end
        end

        drain_results();
        $display("Covered %0d tick requests and %0d register writes in jog and interlock modes,",
                 requests_sent, reg_writes);
        $display("with idle/stall mixes, a %0d-tick jog hold and a %0d-cycle output hold-off.",
                 LONG_HOLD_ITEMS, HOLD_OFF_CYCLES);
        if (mismatches == 0)
            $display("PASS relay_interlock_pulse_controller");
        else
            $display("FAIL relay_interlock_pulse_controller");
        $finish;
    end

endmodule

>>> sim.f
design/rlyip_pkg.sv
design/rlyip_cfg_regs.sv
design/rlyip_tick_engine.sv
design/relay_interlock_pulse_controller.sv
tb/rlyip_tick_checker.sv
tb/testbench.sv
